// File: hw/rtl/bbcd_pkg.sv
// bbcd_pkg: shared types and constants of the block buffer cache directory
// request and response structs, entry word layout, opcodes, status codes, fsm states
// no dependencies
package bbcd_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int DEV_W     = 16;
  localparam int BLK_W     = 32;
  localparam int ENT_W     = 5;
  localparam int TICK_W    = 32;
  localparam int CNT_W     = 8;
  localparam int SLOT_W    = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_LOOK,
    S_DONE
  } state_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [DEV_W-1:0]    device;
    logic [BLK_W-1:0]    block_number;
    logic [ENT_W-1:0]    entry;
    logic [TICK_W-1:0]   now_tick;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              needs_fetch;
    status_e           status;
  } rsp_t;

  typedef struct packed {
    logic [DEV_W-1:0]  tag_device;
    logic [BLK_W-1:0]  tag_block;
    logic [CNT_W-1:0]  ref_count;
    logic [TICK_W-1:0] last_release;
  } word_t;

  localparam int WORD_W = $bits(word_t);

endpackage

// File: hw/rtl/bbcd_ram.sv
// bbcd_ram: generic single-write, single-read ram with registered read data
// width and depth set by parameters; no dependencies
module bbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/block_buffer_cache_directory.sv
// block_buffer_cache_directory: tag lookup, lru victim choice and reference counts
// over a pool of buffer entries; entry words live in bbcd_ram, flags in flops
// depends on bbcd_pkg and bbcd_ram
//
//   channel | dir | handshake               | payload
//   in      | in  | in_valid_i / in_stall_o  | in_req_i   (bbcd_pkg::req_t)
//   out     | out | out_valid_o / out_stall_i| out_rsp_o  (bbcd_pkg::rsp_t)
//
// a read request does one ram read per entry through a single tag and tick comparator,
// then passes through a write-back state and an output load state.
// release, pin and unpin do one ram read, one write-back and an output load.
// in_stall_o is high from acceptance until the response is loaded into the output
// register; a response waiting under out_stall_i does not block the next request.
// reset clears all per-entry flags at once; no clearing pass is needed.
module block_buffer_cache_directory (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bbcd_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bbcd_pkg::rsp_t out_rsp_o
);

  localparam int N  = bbcd_pkg::ENTRIES;
  localparam int IW = bbcd_pkg::IDX_W;

  bbcd_pkg::state_e state_q, state_d;
  logic             out_vld_q, out_vld_d;
  logic [N-1:0]     assigned_q, assigned_d;
  logic [N-1:0]     dvalid_q, dvalid_d;
  logic [N-1:0]     wvld_q, wvld_d;
  logic             hit_found_q, hit_found_d;
  logic             vic_found_q, vic_found_d;

  bbcd_pkg::req_t   req_q, req_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    hit_idx_q, hit_idx_d;
  bbcd_pkg::word_t  hit_word_q, hit_word_d;
  logic [IW-1:0]    vic_idx_q, vic_idx_d;
  logic [bbcd_pkg::TICK_W-1:0] vic_lr_q, vic_lr_d;
  bbcd_pkg::rsp_t   res_q, res_d;
  bbcd_pkg::rsp_t   out_q, out_d;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  bbcd_pkg::word_t  ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [bbcd_pkg::WORD_W-1:0] ram_rdata;

  logic             in_acc;
  logic [IW-1:0]    look_idx;
  logic             look_in_range;
  bbcd_pkg::word_t  scan_word;
  bbcd_pkg::word_t  look_word;
  logic             scan_hit;
  logic             scan_free;

  bbcd_ram #(
    .WIDTH (bbcd_pkg::WORD_W),
    .DEPTH (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != bbcd_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  assign look_idx      = IW'(req_q.entry);
  assign look_in_range = ({27'd0, req_q.entry} < 32'(N));

  // never-written entries read as zero
  assign scan_word = wvld_q[cnt_q]    ? bbcd_pkg::word_t'(ram_rdata) : '0;
  assign look_word = wvld_q[look_idx] ? bbcd_pkg::word_t'(ram_rdata) : '0;

  assign scan_hit  = assigned_q[cnt_q]
                  && (scan_word.tag_device == req_q.device)
                  && (scan_word.tag_block == req_q.block_number);
  assign scan_free = (scan_word.ref_count == '0);

  always_comb begin
    state_d     = state_q;
    out_vld_d   = out_vld_q;
    assigned_d  = assigned_q;
    dvalid_d    = dvalid_q;
    wvld_d      = wvld_q;
    hit_found_d = hit_found_q;
    vic_found_d = vic_found_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    hit_idx_d   = hit_idx_q;
    hit_word_d  = hit_word_q;
    vic_idx_d   = vic_idx_q;
    vic_lr_d    = vic_lr_q;
    res_d       = res_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      bbcd_pkg::S_IDLE: begin
        ram_raddr = (in_req_i.opcode == bbcd_pkg::OP_READ) ? '0 : IW'(in_req_i.entry);
        if (in_acc) begin
          req_d       = in_req_i;
          cnt_d       = '0;
          hit_found_d = 1'b0;
          vic_found_d = 1'b0;
          state_d     = (in_req_i.opcode == bbcd_pkg::OP_READ) ? bbcd_pkg::S_SCAN
                                                               : bbcd_pkg::S_LOOK;
        end
      end

      bbcd_pkg::S_SCAN: begin
        ram_raddr = cnt_q + IW'(1);
        if (scan_hit && !hit_found_q) begin
          hit_found_d = 1'b1;
          hit_idx_d   = cnt_q;
          hit_word_d  = scan_word;
        end
        if (scan_free && (!vic_found_q || (scan_word.last_release < vic_lr_q))) begin
          vic_found_d = 1'b1;
          vic_idx_d   = cnt_q;
          vic_lr_d    = scan_word.last_release;
        end
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(N - 1)) begin
          state_d = bbcd_pkg::S_WRITE;
        end
      end

      bbcd_pkg::S_WRITE: begin
        if (hit_found_q) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_q;
          ram_wdata = hit_word_q;
          if (hit_word_q.ref_count != bbcd_pkg::COUNT_MAX) begin
            ram_wdata.ref_count = hit_word_q.ref_count + 8'd1;
          end
          dvalid_d[hit_idx_q] = 1'b1;
          res_d.slot        = bbcd_pkg::SLOT_W'(hit_idx_q);
          res_d.hit         = 1'b1;
          res_d.needs_fetch = !dvalid_q[hit_idx_q];
          res_d.status      = bbcd_pkg::ST_OK;
        end else if (vic_found_q) begin
          ram_we                 = 1'b1;
          ram_waddr              = vic_idx_q;
          ram_wdata.tag_device   = req_q.device;
          ram_wdata.tag_block    = req_q.block_number;
          ram_wdata.ref_count    = 8'd1;
          ram_wdata.last_release = vic_lr_q;
          assigned_d[vic_idx_q]  = 1'b1;
          dvalid_d[vic_idx_q]    = 1'b1;
          wvld_d[vic_idx_q]      = 1'b1;
          res_d.slot        = bbcd_pkg::SLOT_W'(vic_idx_q);
          res_d.hit         = 1'b0;
          res_d.needs_fetch = 1'b1;
          res_d.status      = bbcd_pkg::ST_OK;
        end else begin
          res_d.slot        = '0;
          res_d.hit         = 1'b0;
          res_d.needs_fetch = 1'b0;
          res_d.status      = bbcd_pkg::ST_NO_FREE;
        end
        state_d = bbcd_pkg::S_DONE;
      end

      bbcd_pkg::S_LOOK: begin
        res_d.slot        = req_q.entry;
        res_d.hit         = 1'b0;
        res_d.needs_fetch = 1'b0;
        res_d.status      = bbcd_pkg::ST_OK;
        ram_waddr         = look_idx;
        ram_wdata         = look_word;
        if (look_in_range) begin
          if (req_q.opcode == bbcd_pkg::OP_PIN) begin
            ram_we           = 1'b1;
            wvld_d[look_idx] = 1'b1;
            if (look_word.ref_count != bbcd_pkg::COUNT_MAX) begin
              ram_wdata.ref_count = look_word.ref_count + 8'd1;
            end
          end else if (look_word.ref_count == '0) begin
            res_d.status = bbcd_pkg::ST_UNDERFLOW;
          end else begin
            ram_we              = 1'b1;
            wvld_d[look_idx]    = 1'b1;
            ram_wdata.ref_count = look_word.ref_count - 8'd1;
            if ((req_q.opcode == bbcd_pkg::OP_RELEASE) && (look_word.ref_count == 8'd1)) begin
              ram_wdata.last_release = req_q.now_tick;
            end
          end
        end
        state_d = bbcd_pkg::S_DONE;
      end

      bbcd_pkg::S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = bbcd_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bbcd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbcd_pkg::S_IDLE;
      out_vld_q   <= 1'b0;
      assigned_q  <= '0;
      dvalid_q    <= '0;
      wvld_q      <= '0;
      hit_found_q <= 1'b0;
      vic_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_vld_q   <= out_vld_d;
      assigned_q  <= assigned_d;
      dvalid_q    <= dvalid_d;
      wvld_q      <= wvld_d;
      hit_found_q <= hit_found_d;
      vic_found_q <= vic_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cnt_q      <= cnt_d;
    hit_idx_q  <= hit_idx_d;
    hit_word_q <= hit_word_d;
    vic_idx_q  <= vic_idx_d;
    vic_lr_q   <= vic_lr_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // an accepted request always starts a scan or a lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == bbcd_pkg::S_SCAN || state_q == bbcd_pkg::S_LOOK))
    else $error("accepted request did not start work");

  // ram is written only in the write-back states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bbcd_pkg::S_WRITE || state_q == bbcd_pkg::S_LOOK))
    else $error("ram write outside write-back");

  // a new response comes only from the output load state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !$past(out_vld_q && out_stall_i) && !$past(!out_vld_q) ? 1'b0 : 1'b1)
    || $past(state_q == bbcd_pkg::S_DONE))
    else $error("response loaded outside done state");

  // an assigned entry always has a written ram word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (assigned_q & ~wvld_q) == '0)
    else $error("assigned entry without ram word");

  // a hit response is never flagged as an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.hit) |-> (out_q.status == bbcd_pkg::ST_OK))
    else $error("hit response with error status");

endmodule

// File: tb/sv/tb.sv
// tb: self-checking testbench for block_buffer_cache_directory
// predicts every response from its own copy of the directory state, checks it in order
// depends on bbcd_pkg and the block_buffer_cache_directory rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbcd_pkg::*;

  localparam int ITEMS = 1750;
  localparam int POOL = 40;
  localparam int STORM_LEN = 260;
  localparam int HOLD_START = 4000;
  localparam int HOLD_LEN = 600;

  localparam int M_FILL = 0;
  localparam int M_CHURN = 1;
  localparam int M_DRAIN = 2;
  localparam int M_STORM_PIN = 3;
  localparam int M_STORM_FREE = 4;

  localparam int STALL_NONE = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_PERIODIC = 3;

  class cache_scoreboard;
    logic [DEV_W-1:0]  tag_dev [ENTRIES];
    logic [BLK_W-1:0]  tag_blk [ENTRIES];
    logic [CNT_W-1:0]  refs [ENTRIES];
    logic [TICK_W-1:0] freed_at [ENTRIES];
    bit                valid_data [ENTRIES];
    bit                in_use [ENTRIES];
    rsp_t              pending [$];
    int                errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i] = '0;
        freed_at[i] = '0;
        valid_data[i] = 1'b0;
        in_use[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   victim;
      int   idx;
      bit   found;
      e = '0;
      e.slot = r.entry;
      e.status = ST_OK;
      if (r.opcode == OP_READ) begin
        e.slot = '0;
        found = 1'b0;
        victim = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && in_use[i] && tag_dev[i] == r.device && tag_blk[i] == r.block_number) begin
            found = 1'b1;
            victim = i;
          end
        end
        if (found) begin
          if (refs[victim] != COUNT_MAX) refs[victim]++;
          e.slot = SLOT_W'(victim);
          e.hit = 1'b1;
          e.needs_fetch = !valid_data[victim];
          valid_data[victim] = 1'b1;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (refs[i] == 0 && (!found || freed_at[i] < freed_at[victim])) begin
              victim = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            e.status = ST_NO_FREE;
          end else begin
            tag_dev[victim] = r.device;
            tag_blk[victim] = r.block_number;
            refs[victim] = CNT_W'(1);
            in_use[victim] = 1'b1;
            valid_data[victim] = 1'b1;
            e.slot = SLOT_W'(victim);
            e.needs_fetch = 1'b1;
          end
        end
      end else if (int'(r.entry) < ENTRIES) begin
        idx = int'(r.entry);
        if (r.opcode == OP_PIN) begin
          if (refs[idx] != COUNT_MAX) refs[idx]++;
        end else if (refs[idx] == 0) begin
          e.status = ST_UNDERFLOW;
        end else begin
          refs[idx]--;
          if (r.opcode == OP_RELEASE && refs[idx] == 0) freed_at[idx] = r.now_tick;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected response slot %0d hit %0b fetch %0b status %0d",
                 $time, got.slot, got.hit, got.needs_fetch, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.slot !== want.slot) begin
        errors++;
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
      end
      if (got.hit !== want.hit) begin
        errors++;
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
      end
      if (got.needs_fetch !== want.needs_fetch) begin
        errors++;
        $display("%0t: needs_fetch expected %0b actual %0b", $time, want.needs_fetch,
                 got.needs_fetch);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
    endfunction

    function int held_entry();
      int held [$];
      for (int i = 0; i < ENTRIES; i++) if (refs[i] != 0) held.push_back(i);
      if (held.size() == 0) return -1;
      return held[$urandom_range(held.size() - 1)];
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  req_t   in_req_i;
  logic   out_valid_o;
  logic   out_stall_i;
  rsp_t   out_rsp_o;

  cache_scoreboard sb = new();

  logic [DEV_W-1:0]  pool_dev [POOL];
  logic [BLK_W-1:0]  pool_blk [POOL];
  logic [TICK_W-1:0] tick_now;
  int                storm_entry;

  block_buffer_cache_directory u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
    end
  end

  function automatic req_t mk(opcode_e op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                              logic [ENT_W-1:0] ent, logic [TICK_W-1:0] tk);
    req_t r;
    r.opcode = op;
    r.device = dev;
    r.block_number = blk;
    r.entry = ent;
    r.now_tick = tk;
    return r;
  endfunction

  function automatic logic [TICK_W-1:0] next_tick();
    case ($urandom_range(9))
      6: return tick_now;
      7: return '0;
      8: return '1;
      9: return $urandom;
      default: begin
        tick_now += $urandom_range(1, 50);
        return tick_now;
      end
    endcase
  endfunction

  function automatic req_t make_request(int mode);
    req_t r;
    int   roll;
    int   k;
    int   e;
    r.opcode = OP_READ;
    r.device = DEV_W'($urandom);
    r.block_number = $urandom;
    r.entry = ENT_W'($urandom);
    r.now_tick = next_tick();
    roll = $urandom_range(99);
    k = $urandom_range(POOL - 1);
    e = sb.held_entry();
    case (mode)
      M_FILL: begin
        if (roll >= 95) r.opcode = OP_PIN;
        else if (roll >= 80) begin
          r.device = pool_dev[k];
          r.block_number = pool_blk[k];
        end
      end
      M_CHURN: begin
        if (roll < 45) begin
          r.device = pool_dev[k];
          r.block_number = pool_blk[k];
        end else if (roll < 55) begin
          r.opcode = OP_READ;
        end else if (roll < 95) begin
          r.opcode = (roll < 75) ? OP_RELEASE : (roll < 85) ? OP_PIN : OP_UNPIN;
          if (e >= 0) r.entry = ENT_W'(e);
        end else begin
          r.opcode = opcode_e'($urandom_range(3));
        end
      end
      M_DRAIN: begin
        if (roll < 80) begin
          r.opcode = (roll < 70) ? OP_RELEASE : OP_UNPIN;
          if (e >= 0) r.entry = ENT_W'(e);
        end else if (roll < 90) begin
          r.device = pool_dev[k];
          r.block_number = pool_blk[k];
        end else begin
          r.opcode = opcode_e'($urandom_range(3));
        end
      end
      M_STORM_PIN: begin
        r.opcode = OP_PIN;
        r.entry = ENT_W'(storm_entry);
      end
      default: begin
        r.opcode = OP_RELEASE;
        r.entry = ENT_W'(storm_entry);
      end
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic offer(input req_t r);
    in_req_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic run_segment(input int mode, input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && left > 0; j++) begin
        offer(make_request(mode));
        left--;
      end
      if ($urandom_range(4) != 0) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    int stretch;
    int style;
    int cyc;
    out_stall_i = 1'b0;
    stretch = 0;
    style = STALL_NONE;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (stretch == 0) begin
        stretch = $urandom_range(20, 200);
        style = $urandom_range(3);
      end
      stretch--;
      // long hold-off so the block fills up and stalls its input
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_stall_i <= 1'b1;
      end else begin
        case (style)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(9) < 3);
          STALL_HEAVY: out_stall_i <= ($urandom_range(9) < 8);
          default:     out_stall_i <= ((cyc % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int total;
    int round;
    int n;
    in_valid_i = 1'b0;
    in_req_i = '0;
    rst_ni = 1'b0;
    tick_now = 32'd100;
    storm_entry = 0;
    for (int k = 0; k < POOL; k++) begin
      pool_dev[k] = ($urandom_range(3) == 0) ? 16'hFFFF : DEV_W'($urandom_range(7));
      pool_blk[k] = (k < 20) ? BLK_W'(k) : $urandom;
    end
    // same block number on other devices
    for (int k = 20; k < 26; k++) pool_blk[k] = pool_blk[k - 20];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    offer(mk(OP_READ, '0, '0, '0, '0));
    offer(mk(OP_READ, '0, '0, '1, '1));
    offer(mk(OP_READ, '1, '1, '0, '0));
    pause(3);
    offer(mk(OP_READ, '1, '0, '0, '0));
    offer(mk(OP_READ, '0, '1, '0, '0));
    offer(mk(OP_PIN, '1, '1, 5'd1, '0));
    offer(mk(OP_UNPIN, '0, '0, 5'd1, '0));
    pause(1);
    offer(mk(OP_RELEASE, '0, '0, 5'd1, '1));
    offer(mk(OP_RELEASE, '0, '0, 5'd1, 32'd5));
    offer(mk(OP_UNPIN, '0, '0, '1, '0));
    offer(mk(OP_RELEASE, '0, '0, 5'd2, '0));
    offer(mk(OP_READ, '1, '1, '0, '0));
    offer(mk(OP_PIN, '0, '0, '1, '0));
    pause(5);
    offer(mk(OP_READ, 16'h1234, 32'h89AB_CDEF, '0, '0));
    offer(mk(OP_RELEASE, '0, '0, 5'd0, 32'd7));
    offer(mk(OP_RELEASE, '0, '0, 5'd0, 32'd7));
    offer(mk(OP_RELEASE, '0, '0, 5'd3, 32'd7));
    offer(mk(OP_UNPIN, '0, '0, '1, '0));
    offer(mk(OP_READ, 16'h5A5A, 32'hA5A5_A5A5, '1, '1));
    offer(mk(OP_READ, 16'h5A5A, 32'hA5A5_A5A5, '0, '0));

    total = 0;
    round = 0;
    while (total < ITEMS) begin
      n = $urandom_range(36, 60);
      run_segment(M_FILL, n);
      total += n;
      n = $urandom_range(60, 120);
      run_segment(M_CHURN, n);
      total += n;
      if (round == 1) begin
        storm_entry = $urandom_range(ENTRIES - 1);
        run_segment(M_STORM_PIN, STORM_LEN);
        run_segment(M_STORM_FREE, STORM_LEN);
        total += 2 * STORM_LEN;
      end
      n = $urandom_range(40, 90);
      run_segment(M_DRAIN, n);
      total += n;
      round++;
    end
    pause(1);

    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
